// File: rtl/tsb_pkg.sv
// Shared widths, field offsets, register indexes and control types for triangle setup binning.
package tsb_pkg;

    localparam int COORD_W     = 17;
    localparam int DEPTH_W     = 24;
    localparam int SIZE_W      = 13;
    localparam int LIMIT_W     = 16;
    localparam int IDX_W       = 16;
    localparam int COUNT_W     = 9;
    localparam int SLOT_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int FRAC_SHIFT  = 12;
    localparam int PIXEL_SHIFT = 4;
    localparam int PIXEL_W     = COORD_W - PIXEL_SHIFT;
    localparam int PROD_W      = COORD_W + SIZE_W;

    // The reciprocal is 2^32 / z with a 24-bit quotient.
    localparam int RECIP_EXP   = 32;
    localparam int DIV_BITS    = DEPTH_W;
    localparam int INIT_REM    = 2 ** (RECIP_EXP - DIV_BITS);

    // Input item layout, per vertex: x, y, z.
    localparam int VERT_W      = 2 * COORD_W + DEPTH_W;
    localparam int IN_BITS     = 3 * VERT_W;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

    // Result layout: screen coordinates, reciprocal depths, slot, index.
    localparam int INV_LSB     = 6 * COORD_W;
    localparam int SLOT_LSB    = INV_LSB + 3 * DEPTH_W;
    localparam int IDX_LSB     = SLOT_LSB + SLOT_W;
    localparam int OUT_BITS    = IDX_LSB + IDX_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    localparam int GROUP_SIZE_DEF  = 256;
    localparam int TILE_PIXELS_DEF = 16;
    localparam int SMALL_TILES_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_LIMIT = 2'd2;

    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic scale;
        logic div_step;
        logic commit;
    } tsb_cmd_t;

    typedef struct packed {
        logic in_range;
    } tsb_status_t;

endpackage

// File: rtl/tsb_recip.sv
// Restoring divider that forms a saturated 2^32 / z, one quotient bit per step.
module tsb_recip
    import tsb_pkg::*;
(
    input  logic               clk,
    input  logic               start,
    input  logic               step,
    input  logic [DEPTH_W-1:0] z,
    output logic [DEPTH_W-1:0] q
);

    logic [DEPTH_W-1:0] rem_reg;
    logic [DEPTH_W-1:0] div_reg;
    logic [DEPTH_W-1:0] quo_reg;
    logic               sat_reg;

    logic [DEPTH_W:0]   rem_dbl;
    logic [DEPTH_W:0]   rem_diff;
    logic               take;
    logic [DEPTH_W-1:0] rem_next;

    // Remainder stays below the divisor, so doubling it needs one extra bit.
    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        rem_diff = rem_dbl - {1'b0, div_reg};
        take     = (rem_dbl >= {1'b0, div_reg});
        rem_next = take ? rem_diff[DEPTH_W-1:0] : rem_dbl[DEPTH_W-1:0];
    end

    // A depth at or below the initial remainder gives a quotient past 24 bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEPTH_W'(INIT_REM);
            div_reg <= z;
            sat_reg <= (z <= DEPTH_W'(INIT_REM));
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DEPTH_W-2:0], take};
        end
    end

    assign q = sat_reg ? {DEPTH_W{1'b1}} : quo_reg;

endmodule

// File: rtl/tsb_ctrl.sv
// Controller state machine that sequences load, scaling, division and binning.
module tsb_ctrl
    import tsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  tsb_status_t status,
    output tsb_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_BIN   = 4'b1000
    } state_t;

    localparam int STEP_W = (DIV_BITS > 1) ? $clog2(DIV_BITS) : 1;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // A triangle at or beyond the limit only advances the stream and group positions.
                if (status.in_range)
                begin
                    cmd.scale  = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_BITS - 1))
                begin
                    state_next = S_BIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_BIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/tsb_datapath.sv
// Datapath: configuration registers, coordinate scaling, reciprocal units, box and slot logic.
module tsb_datapath
    import tsb_pkg::*;
#(
    parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
    parameter int TILE_PIXELS = TILE_PIXELS_DEF,
    parameter int SMALL_TILES = SMALL_TILES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_W-1:0]       s_tdata,
    input  tsb_cmd_t              cmd,
    output tsb_status_t           status,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tuser
);

    localparam int GRP_W   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int SMALL_W = PIXEL_W + 2;
    localparam logic [SMALL_W-1:0] SMALL_LIMIT = SMALL_W'(SMALL_TILES * TILE_PIXELS);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [IDX_W-1:0]   counter_reg;
    logic [GRP_W-1:0]   grp_pos_reg;
    logic [COUNT_W-1:0] small_cnt_reg;
    logic [COUNT_W-1:0] large_cnt_reg;
    logic               in_range_reg;

    logic [COORD_W-1:0] vx_reg [3];
    logic [COORD_W-1:0] vy_reg [3];
    logic [DEPTH_W-1:0] vz_reg [3];
    logic [IDX_W-1:0]   idx_reg;
    logic [COORD_W-1:0] sx_reg [3];
    logic [COORD_W-1:0] sy_reg [3];
    logic [DEPTH_W-1:0] inv    [3];

    logic [OUT_W-1:0]   out_data_reg;
    logic               out_small_reg;

    logic [PROD_W-1:0]  prod_x [3];
    logic [PROD_W-1:0]  prod_y [3];
    logic [PIXEL_W-1:0] dim_x;
    logic [PIXEL_W-1:0] dim_y;
    logic [PIXEL_W-1:0] dim;
    logic               tri_small;
    logic [COUNT_W-1:0] slot;
    logic               grp_last;

    function automatic logic [COORD_W-1:0] sat_scale(input logic [PROD_W-1:0] p);
        logic [PROD_W-FRAC_SHIFT-1:0] sh;
        sh = p[PROD_W-1:FRAC_SHIFT];
        return sh[PROD_W-FRAC_SHIFT-1] ? {COORD_W{1'b1}} : sh[COORD_W-1:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] span3(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b,
                                                 input logic [PIXEL_W-1:0] c);
        logic [PIXEL_W-1:0] hi;
        logic [PIXEL_W-1:0] lo;
        hi = a;
        lo = a;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        return hi - lo;
    endfunction

    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            prod_x[v] = PROD_W'(vx_reg[v]) * PROD_W'(width_reg);
            prod_y[v] = PROD_W'(vy_reg[v]) * PROD_W'(height_reg);
        end
    end

    always_comb
    begin
        dim_x = span3(sx_reg[0][COORD_W-1:PIXEL_SHIFT], sx_reg[1][COORD_W-1:PIXEL_SHIFT],
                      sx_reg[2][COORD_W-1:PIXEL_SHIFT]);
        dim_y = span3(sy_reg[0][COORD_W-1:PIXEL_SHIFT], sy_reg[1][COORD_W-1:PIXEL_SHIFT],
                      sy_reg[2][COORD_W-1:PIXEL_SHIFT]);
        dim       = (dim_x > dim_y) ? dim_x : dim_y;
        tri_small = ({2'b00, dim} < SMALL_LIMIT);
        slot      = tri_small ? small_cnt_reg : large_cnt_reg;
    end

    // The group position also restarts when the stream position wraps to zero.
    assign grp_last = (grp_pos_reg == GRP_W'(GROUP_SIZE - 1)) || (counter_reg == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            limit_reg     <= LIMIT_RESET;
            counter_reg   <= '0;
            grp_pos_reg   <= '0;
            small_cnt_reg <= '0;
            large_cnt_reg <= '0;
            in_range_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:   width_reg  <= cfg_data[SIZE_W-1:0];
                    REG_SCREEN_HEIGHT:  height_reg <= cfg_data[SIZE_W-1:0];
                    REG_TRIANGLE_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.load)
            begin
                in_range_reg <= (counter_reg < limit_reg);
                counter_reg  <= counter_reg + 1'b1;
                grp_pos_reg  <= grp_last ? '0 : grp_pos_reg + 1'b1;
                if (grp_pos_reg == '0)
                begin
                    small_cnt_reg <= '0;
                    large_cnt_reg <= '0;
                end
            end
            if (cmd.commit)
            begin
                if (tri_small)
                begin
                    small_cnt_reg <= small_cnt_reg + 1'b1;
                end
                else
                begin
                    large_cnt_reg <= large_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= counter_reg;
            for (int v = 0; v < 3; v++)
            begin
                vx_reg[v] <= s_tdata[v * VERT_W +: COORD_W];
                vy_reg[v] <= s_tdata[v * VERT_W + COORD_W +: COORD_W];
                vz_reg[v] <= s_tdata[v * VERT_W + 2 * COORD_W +: DEPTH_W];
            end
        end
        if (cmd.scale)
        begin
            for (int v = 0; v < 3; v++)
            begin
                sx_reg[v] <= sat_scale(prod_x[v]);
                sy_reg[v] <= sat_scale(prod_y[v]);
            end
        end
        if (cmd.commit)
        begin
            for (int v = 0; v < 3; v++)
            begin
                out_data_reg[2 * v * COORD_W +: COORD_W]       <= sx_reg[v];
                out_data_reg[(2 * v + 1) * COORD_W +: COORD_W] <= sy_reg[v];
                out_data_reg[INV_LSB + v * DEPTH_W +: DEPTH_W] <= inv[v];
            end
            out_data_reg[SLOT_LSB +: SLOT_W]    <= slot[SLOT_W-1:0];
            out_data_reg[IDX_LSB +: IDX_W]      <= idx_reg;
            out_data_reg[OUT_W-1:OUT_BITS]      <= '0;
            out_small_reg                       <= tri_small;
        end
    end

    for (genvar v = 0; v < 3; v++)
    begin : g_recip
        tsb_recip u_recip
        (
            .clk   (clk),
            .start (cmd.scale),
            .step  (cmd.div_step),
            .z     (vz_reg[v]),
            .q     (inv[v])
        );
    end

    assign status.in_range = in_range_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_small_reg;

endmodule

// File: rtl/triangle_setup_size_binning.sv
// An accepted triangle passes the range check, the 24 steps of the three parallel restoring
// reciprocal dividers and the binning state, which waits while the output register is full.
// A new triangle is taken only after that; a triangle at or beyond the limit skips to idle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, asynchronous) clears the stream position and both slot counts and
// restores the register defaults: width 640, height 480, limit 65535.
module triangle_setup_size_binning
    import tsb_pkg::*;
#(
    parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
    parameter int TILE_PIXELS = TILE_PIXELS_DEF,
    parameter int SMALL_TILES = SMALL_TILES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Triangle input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
    // vert2_x, vert2_y, vert2_z, zero fill.
    input  logic [IN_W-1:0]       s_tdata,
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, low bit up: screen0_x, screen0_y, screen1_x, screen1_y, screen2_x,
    // screen2_y, inv_depth0, inv_depth1, inv_depth2, list_slot, triangle_index, zero fill.
    output logic [OUT_W-1:0]      m_tdata,
    // m_tuser: is_small.
    output logic                  m_tuser
);

    tsb_cmd_t    cmd;
    tsb_status_t status;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    tsb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsb_datapath #(
        .GROUP_SIZE  (GROUP_SIZE),
        .TILE_PIXELS (TILE_PIXELS),
        .SMALL_TILES (SMALL_TILES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A result is never written over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result written over a pending result");

    // One triangle at a time: after a request is taken, input stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted triangle");

    // The output only becomes valid from a committed result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("output valid without a committed result");

    // Loading a new triangle never coincides with a division step or a commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.commit && !cmd.div_step))
        else $error("load overlaps division or commit");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the triangle setup and size binning block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 600;
    localparam int NORM_ONE     = 65536;
    localparam int SMALL_DIM    = SMALL_TILES_DEF * TILE_PIXELS_DEF;

    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

    localparam logic [COORD_W-1:0] SCREEN_SAT = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT  = '1;

    typedef struct packed {
        logic [5:0][COORD_W-1:0] scr;
        logic [2:0][DEPTH_W-1:0] inv;
        logic                    tri_small;
        logic [SLOT_W-1:0]       slot;
        logic [IDX_W-1:0]        idx;
    } setup_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;

    // Shadow of the block's registers and counters.
    logic [SIZE_W-1:0]  width_reg  = WIDTH_RESET;
    logic [SIZE_W-1:0]  height_reg = HEIGHT_RESET;
    logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;
    logic [IDX_W-1:0]   tri_pos    = '0;
    logic [COUNT_W-1:0] small_cnt  = '0;
    logic [COUNT_W-1:0] large_cnt  = '0;

    logic [IN_W-1:0] pending_tris[$];
    setup_result_t   expected_setups[$];

    logic idle_en  = 1'b1;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;
    int   rx_gap = 0;
    int   tx_gap = 0;
    int   cycles = 0;
    int   errors = 0;
    int   accepted_cnt = 0;
    int   result_cnt = 0;
    int   small_seen = 0;
    int   cfg_writes = 0;

    triangle_setup_size_binning dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [COORD_W-1:0] to_screen(input logic [COORD_W-1:0] c,
                                                     input logic [SIZE_W-1:0] size);
        logic [PROD_W-1:0] prod;
        prod = (PROD_W'(c) * PROD_W'(size)) >> FRAC_SHIFT;
        return (prod > PROD_W'(SCREEN_SAT)) ? SCREEN_SAT : prod[COORD_W-1:0];
    endfunction

    function automatic logic [DEPTH_W-1:0] recip_depth(input logic [DEPTH_W-1:0] z);
        logic [63:0] q;
        if (z == '0)
            return DEPTH_SAT;
        q = (64'd1 << RECIP_EXP) / 64'(z);
        return (q > 64'(DEPTH_SAT)) ? DEPTH_SAT : q[DEPTH_W-1:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] pixel_span(input logic [PIXEL_W-1:0] a,
                                                      input logic [PIXEL_W-1:0] b,
                                                      input logic [PIXEL_W-1:0] c);
        logic [PIXEL_W-1:0] hi;
        logic [PIXEL_W-1:0] lo;
        hi = a;
        lo = a;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        return hi - lo;
    endfunction

    // Advances the shadow state by one triangle and queues its setup if it is in range.
    function automatic void predict_setup(input logic [IN_W-1:0] word);
        setup_result_t      r;
        logic [IDX_W-1:0]   pos;
        logic [PIXEL_W-1:0] px[3];
        logic [PIXEL_W-1:0] py[3];
        logic [PIXEL_W-1:0] dim_x;
        logic [PIXEL_W-1:0] dim_y;
        pos = tri_pos;
        tri_pos = tri_pos + 1'b1;
        if (pos % GROUP_SIZE_DEF == 0)
        begin
            small_cnt = '0;
            large_cnt = '0;
        end
        if (pos >= limit_reg)
            return;
        for (int v = 0; v < 3; v++)
        begin
            r.scr[2*v]   = to_screen(word[v*VERT_W +: COORD_W], width_reg);
            r.scr[2*v+1] = to_screen(word[v*VERT_W + COORD_W +: COORD_W], height_reg);
            r.inv[v]     = recip_depth(word[v*VERT_W + 2*COORD_W +: DEPTH_W]);
            px[v] = r.scr[2*v][COORD_W-1:PIXEL_SHIFT];
            py[v] = r.scr[2*v+1][COORD_W-1:PIXEL_SHIFT];
        end
        dim_x = pixel_span(px[0], px[1], px[2]);
        dim_y = pixel_span(py[0], py[1], py[2]);
        r.tri_small = ((dim_x > dim_y) ? dim_x : dim_y) < SMALL_DIM;
        if (r.tri_small)
        begin
            r.slot = small_cnt[SLOT_W-1:0];
            small_cnt = small_cnt + 1'b1;
        end
        else
        begin
            r.slot = large_cnt[SLOT_W-1:0];
            large_cnt = large_cnt + 1'b1;
        end
        r.idx = pos;
        expected_setups.push_back(r);
    endfunction

    function automatic logic [IN_W-1:0] make_triangle(
        input int unsigned x0, input int unsigned y0, input int unsigned z0,
        input int unsigned x1, input int unsigned y1, input int unsigned z1,
        input int unsigned x2, input int unsigned y2, input int unsigned z2);
        logic [IN_W-1:0] w;
        w = '0;
        w[0*VERT_W +: COORD_W]             = x0[COORD_W-1:0];
        w[0*VERT_W + COORD_W +: COORD_W]   = y0[COORD_W-1:0];
        w[0*VERT_W + 2*COORD_W +: DEPTH_W] = z0[DEPTH_W-1:0];
        w[1*VERT_W +: COORD_W]             = x1[COORD_W-1:0];
        w[1*VERT_W + COORD_W +: COORD_W]   = y1[COORD_W-1:0];
        w[1*VERT_W + 2*COORD_W +: DEPTH_W] = z1[DEPTH_W-1:0];
        w[2*VERT_W +: COORD_W]             = x2[COORD_W-1:0];
        w[2*VERT_W + COORD_W +: COORD_W]   = y2[COORD_W-1:0];
        w[2*VERT_W + 2*COORD_W +: DEPTH_W] = z2[DEPTH_W-1:0];
        return w;
    endfunction

    // Vertices cluster around a base point; the spread decides how many land small.
    function automatic logic [IN_W-1:0] rand_triangle();
        int unsigned spread;
        int unsigned t;
        int unsigned base[2];
        int unsigned c[6];
        int unsigned z[3];
        case ($urandom_range(0, 3))
            0: spread = 64;
            1: spread = 1024;
            2: spread = 8192;
            default: spread = NORM_ONE;
        endcase
        base[0] = $urandom_range(0, NORM_ONE);
        base[1] = $urandom_range(0, NORM_ONE);
        for (int i = 0; i < 6; i++)
        begin
            t = base[i % 2] + $urandom_range(0, spread);
            if ($urandom_range(0, 15) == 0)
                t = $urandom_range(0, 1) ? NORM_ONE : 0;
            c[i] = (t > NORM_ONE) ? NORM_ONE : t;
        end
        for (int v = 0; v < 3; v++)
        begin
            case ($urandom_range(0, 7))
                0: z[v] = 0;
                1: z[v] = $urandom_range(1, 300);
                2: z[v] = DEPTH_SAT;
                default: z[v] = $urandom() & DEPTH_SAT;
            endcase
        end
        return make_triangle(c[0], c[1], z[0], c[2], c[3], z[1], c[4], c[5], z[2]);
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_setup();
        setup_result_t e;
        if (expected_setups.size() == 0)
        begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual m_tdata %h m_tuser %b",
                     $time, m_tdata, m_tuser);
            return;
        end
        e = expected_setups.pop_front();
        for (int i = 0; i < 6; i++)
            check_field($sformatf("screen%0d_%s", i / 2, (i % 2) ? "y" : "x"),
                        e.scr[i], m_tdata[i*COORD_W +: COORD_W]);
        for (int k = 0; k < 3; k++)
            check_field($sformatf("inv_depth%0d", k), e.inv[k],
                        m_tdata[INV_LSB + k*DEPTH_W +: DEPTH_W]);
        check_field("is_small", e.tri_small, m_tuser);
        check_field("list_slot", e.slot, m_tdata[SLOT_LSB +: SLOT_W]);
        check_field("triangle_index", e.idx, m_tdata[IDX_LSB +: IDX_W]);
        result_cnt++;
        if (e.tri_small)
            small_seen++;
    endtask

    // Request driver: takes triangles from the pending queue, with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_setup(s_tdata);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_tris.size() > 0)
                begin
                    s_tdata <= pending_tris.pop_front();
                    s_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        tx_gap <= $urandom_range(1, 5);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls and the occasional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_setup();
            if (hold_ack != hold_req)
            begin
                hold_ack <= hold_req;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                rx_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     expected_setups.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_SCREEN_WIDTH:   width_reg  = val[SIZE_W-1:0];
            REG_SCREEN_HEIGHT:  height_reg = val[SIZE_W-1:0];
            REG_TRIANGLE_LIMIT: limit_reg  = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Waits for the stream to drain, then lets an out-of-range triangle finish too.
    task automatic wait_idle();
        while (pending_tris.size() != 0 || s_tvalid || expected_setups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_tris.push_back(rand_triangle());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: degenerate, full-screen and depth saturation edges.
        pending_tris.push_back(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_triangle(NORM_ONE, NORM_ONE, DEPTH_SAT,
                                             NORM_ONE, NORM_ONE, DEPTH_SAT,
                                             NORM_ONE, NORM_ONE, DEPTH_SAT));
        pending_tris.push_back(make_triangle(0, 0, 1, NORM_ONE, 0, 256, 0, NORM_ONE, 257));
        pending_tris.push_back(make_triangle(32768, 32768, 65536, 32868, 32800, 131072,
                                             32768, 32900, 32768));
        wait_idle();

        // An unknown register index must leave the settings alone.
        write_reg(REG_UNKNOWN, $urandom_range(0, 65535));
        // At 4096 by 4096 the screen value equals the input, so pixel sizes are exact.
        write_reg(REG_SCREEN_WIDTH, 4096);
        write_reg(REG_SCREEN_HEIGHT, 4096);
        pending_tris.push_back(make_triangle(0, 0, 100, 1023, 0, 200, 0, 500, 300));
        pending_tris.push_back(make_triangle(0, 0, 100, 1024, 0, 200, 500, 500, 300));
        pending_tris.push_back(make_triangle(7, 2000, 9, 7, 3023, 9, 7, 2000, 9));
        pending_tris.push_back(make_triangle(7, 2000, 9, 7, 3024, 9, 7, 2000, 9));
        pending_tris.push_back(make_triangle(131071, 131071, 24'hAAAAAA, 0, 131071,
                                             24'h555555, 131071, 0, 24'h0F0F0F));
        wait_idle();

        // Oversized screen with out-of-range coordinates drives the screen saturation.
        write_reg(REG_SCREEN_WIDTH, 8191);
        write_reg(REG_SCREEN_HEIGHT, 5000);
        pending_tris.push_back(make_triangle(131071, 100000, 65536, NORM_ONE, NORM_ONE, 2,
                                             70000, 0, 3));
        pending_tris.push_back(make_triangle(0, 131071, 0, 131071, 0, 0, 1, 1, 0));
        wait_idle();

        write_reg(REG_SCREEN_WIDTH, 640);
        write_reg(REG_SCREEN_HEIGHT, 480);
        queue_random(400);
        // Hold the result side off while the sender keeps offering triangles.
        hold_req <= hold_req + 1;
        wait_idle();

        write_reg(REG_SCREEN_WIDTH, 1);
        write_reg(REG_SCREEN_HEIGHT, 1);
        queue_random(150);
        wait_idle();

        // A limit part way into the stream, crossing group boundaries beyond it.
        write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 4096));
        write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 4096));
        write_reg(REG_TRIANGLE_LIMIT, int'(tri_pos) + 100);
        queue_random(300);
        wait_idle();

        // With a zero limit nothing comes out, yet the stream position still advances.
        write_reg(REG_TRIANGLE_LIMIT, 0);
        idle_en <= 1'b0;
        queue_random(20);
        wait_idle();
        write_reg(REG_TRIANGLE_LIMIT, 65535);
        write_reg(REG_SCREEN_WIDTH, 4096);
        write_reg(REG_SCREEN_HEIGHT, 4096);
        idle_en <= 1'b1;
        queue_random(60);
        wait_idle();

        write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 4096));
        write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 4096));
        queue_random(450);
        while (pending_tris.size() != 0)
            @(posedge clk);
        idle_en <= 1'b0;
        queue_random(260);
        wait_idle();

        $display("Covered %0d triangles with limits and group boundaries, %0d setups checked,",
                 accepted_cnt, result_cnt);
        $display("%0d of them small, over %0d register writes.", small_seen, cfg_writes);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
